// File: rtl/stok_pkg.sv
// Shared types, token codes and character helpers for the source tokenizer.
package stok_pkg;

    localparam int LINE_W  = 24;
    localparam int VALUE_W = 31;
    localparam int KIND_W  = 6;
    localparam int CHARS_W = 64;
    localparam int LEN_W   = 8;
    localparam int KW_NUM  = 15;
    localparam int KW_TEXT = 9;

    localparam logic [LINE_W-1:0]  LINE_MAX = {LINE_W{1'b1}};
    localparam logic [VALUE_W-1:0] NUM_MAX  = {VALUE_W{1'b1}};

    localparam logic [KIND_W-1:0] K_UNKNOWN    = 6'd0;
    localparam logic [KIND_W-1:0] K_BADCOMMENT = 6'd1;
    localparam logic [KIND_W-1:0] K_IDENT      = 6'd2;
    localparam logic [KIND_W-1:0] K_NUMBER     = 6'd3;
    localparam logic [KIND_W-1:0] K_EQ         = 6'd4;
    localparam logic [KIND_W-1:0] K_NE         = 6'd5;
    localparam logic [KIND_W-1:0] K_LE         = 6'd6;
    localparam logic [KIND_W-1:0] K_GE         = 6'd7;
    localparam logic [KIND_W-1:0] K_LOR        = 6'd8;
    localparam logic [KIND_W-1:0] K_LAND       = 6'd9;
    localparam logic [KIND_W-1:0] K_EOF        = 6'd23;
    localparam logic [KIND_W-1:0] K_NOT        = 6'd24;
    localparam logic [KIND_W-1:0] K_MOD        = 6'd25;
    localparam logic [KIND_W-1:0] K_LPAREN     = 6'd26;
    localparam logic [KIND_W-1:0] K_RPAREN     = 6'd27;
    localparam logic [KIND_W-1:0] K_MUL        = 6'd28;
    localparam logic [KIND_W-1:0] K_ADD        = 6'd29;
    localparam logic [KIND_W-1:0] K_COMMA      = 6'd30;
    localparam logic [KIND_W-1:0] K_SUB        = 6'd31;
    localparam logic [KIND_W-1:0] K_PERIOD     = 6'd32;
    localparam logic [KIND_W-1:0] K_DIV        = 6'd33;
    localparam logic [KIND_W-1:0] K_SEMI       = 6'd34;
    localparam logic [KIND_W-1:0] K_LT         = 6'd35;
    localparam logic [KIND_W-1:0] K_ASSIGN     = 6'd36;
    localparam logic [KIND_W-1:0] K_GT         = 6'd37;
    localparam logic [KIND_W-1:0] K_XOR        = 6'd38;
    localparam logic [KIND_W-1:0] K_BOR        = 6'd39;
    localparam logic [KIND_W-1:0] K_BAND       = 6'd40;
    localparam logic [KIND_W-1:0] K_RSHIFT     = 6'd42;
    localparam logic [KIND_W-1:0] K_LSHIFT     = 6'd43;

    // Keyword text, first byte in the low bits, with length and kind.
    localparam logic [KW_NUM-1:0][8*KW_TEXT-1:0] KW_STR = '{
        72'h00_0000_0000_646f_6d,   // mod
        72'h00_0000_006c_6974_6e75, // until
        72'h00_0000_7461_6570_6572, // repeat
        72'h00_0000_0000_0000_6f64, // do
        72'h00_0000_0065_6c69_6877, // while
        72'h00_0000_0000_6573_6c65, // else
        72'h00_0000_0000_6e65_6874, // then
        72'h00_0000_0000_0000_6669, // if
        72'h00_0000_0000_0064_6e65, // end
        72'h00_0000_006e_6967_6562, // begin
        72'h00_0000_0000_6c6c_6163, // call
        72'h00_6e6f_6974_636e_7566, // function
        72'h65_7275_6465_636f_7270, // procedure
        72'h00_0000_0000_0072_6176, // var
        72'h00_0000_0074_736e_6f63  // const
    };
    localparam logic [KW_NUM-1:0][3:0] KW_LEN = '{
        4'd3, 4'd5, 4'd6, 4'd2, 4'd5, 4'd4, 4'd4, 4'd2, 4'd3, 4'd5, 4'd4, 4'd8,
        4'd9, 4'd3, 4'd5
    };
    localparam logic [KW_NUM-1:0][KIND_W-1:0] KW_KIND = '{
        6'd25, 6'd22, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17, 6'd16, 6'd15, 6'd14,
        6'd41, 6'd13, 6'd12, 6'd11, 6'd10
    };

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_WORD    = 5'b01000,
        MODE_OPER    = 5'b10000
    } scan_mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [LINE_W-1:0]  line;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   len;
    } token_t;

    // All tokens caused by one request; tok1 is used only when two is set.
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } tok_pair_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0d]};
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] op);
        case (op)
            8'h3d:   return K_ASSIGN;
            8'h21:   return K_NOT;
            8'h3e:   return K_GT;
            8'h3c:   return K_LT;
            8'h7c:   return K_BOR;
            default: return K_BAND;
        endcase
    endfunction

    // Bit KIND_W set means the byte does not complete the pending operator.
    function automatic logic [KIND_W:0] pair_kind(input logic [7:0] op, input logic [7:0] c);
        logic [KIND_W:0] r;
        r = {1'b1, K_UNKNOWN};
        case (op)
            8'h3d: if (c == 8'h3d) r = {1'b0, K_EQ};
            8'h21: if (c == 8'h3d) r = {1'b0, K_NE};
            8'h3e:
            begin
                if (c == 8'h3e) r = {1'b0, K_RSHIFT};
                else if (c == 8'h3d) r = {1'b0, K_GE};
            end
            8'h3c:
            begin
                if (c == 8'h3c) r = {1'b0, K_LSHIFT};
                else if (c == 8'h3d) r = {1'b0, K_LE};
            end
            8'h7c: if (c == 8'h7c) r = {1'b0, K_LOR};
            8'h26: if (c == 8'h26) r = {1'b0, K_LAND};
            default: r = {1'b1, K_UNKNOWN};
        endcase
        return r;
    endfunction

endpackage

// File: rtl/stok_ifs.sv
// Channel interfaces: source bytes in, tokens out.
interface stok_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       at_end;
    modport source (output valid, char_in, at_end, input ready);
    modport sink   (input valid, char_in, at_end, output ready);
endinterface

interface stok_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [30:0] token_value;
    logic [23:0] line_number;
    logic [63:0] name_chars;
    logic [7:0]  name_length;
    logic        last_of_item;
    modport source (output valid, token_kind, token_value, line_number, name_chars,
                    name_length, last_of_item, input ready);
    modport sink   (input valid, token_kind, token_value, line_number, name_chars,
                    name_length, last_of_item, output ready);
endinterface

// File: rtl/source_tokenizer.sv
// Top level of the source tokenizer: scanner front end, token queue, output port.
//
// Usage:
//   src: one request per source byte (char_in), or an end marker (at_end = 1)
//        that flushes any pending token, emits eof and reloads the line count
//        from first_line.
//   tok: one request per token; last_of_item marks the final token of a byte.
//        A byte may give zero, one or two tokens.
//   cfg_we / cfg_wdata: write first_line while the block is idle. Reset loads 1.
// Throughput: one source byte per cycle while the queue has room; the output
//   side drains one token per cycle while tok.ready is high, so a byte that gives
//   two tokens is drained one token at a time. The queue of QUEUE_DEPTH entries
//   (one entry per byte that gives tokens) sets how long the sides may run apart.
// Order: a token is registered in the queue at the edge that accepts its byte
//   and is offered on tok once the tokens queued ahead of it have been taken.
// Reset: asynchronous, clears the scan state and empties the queue; line count
//   and first_line return to 1.
// Stall: when tok is held, the queue fills and src.ready drops once it is full;
//   no token is lost or repeated.
module source_tokenizer
    import stok_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = 9,
    parameter int NAME_OUT_CHARS  = 8,
    parameter int QUEUE_DEPTH     = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [LINE_W-1:0] cfg_wdata,
    stok_src_if.sink          src,
    stok_tok_if.source        tok
);

    logic      push_valid, push_ready;
    tok_pair_t push_pair;
    token_t    out_tok;

    // Front end: hold scan state, classify each byte, form its tokens.
    stok_front #(
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
        .NAME_OUT_CHARS  (NAME_OUT_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (src.valid),
        .in_char    (src.char_in),
        .in_end     (src.at_end),
        .in_ready   (src.ready),
        .push_valid (push_valid),
        .push_pair  (push_pair),
        .push_ready (push_ready)
    );

    // Back end: queue token pairs and drain them one token per request.
    stok_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_pair  (push_pair),
        .push_ready (push_ready),
        .out_valid  (tok.valid),
        .out_tok    (out_tok),
        .out_last   (tok.last_of_item),
        .out_ready  (tok.ready)
    );

    assign tok.token_kind  = out_tok.kind;
    assign tok.token_value = out_tok.value;
    assign tok.line_number = out_tok.line;
    assign tok.name_chars  = out_tok.chars;
    assign tok.name_length = out_tok.len;

endmodule

// File: rtl/stok_front.sv
// Scanner front end: classifies each byte, holds scan state, forms token pairs.
module stok_front
    import stok_pkg::*;
#(
    parameter int KEYWORD_MAX_LEN = 9,
    parameter int NAME_OUT_CHARS  = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [LINE_W-1:0] cfg_wdata,
    input  logic              in_valid,
    input  logic [7:0]        in_char,
    input  logic              in_end,
    output logic              in_ready,
    output logic              push_valid,
    output tok_pair_t         push_pair,
    input  logic              push_ready
);

    scan_mode_t         mode_reg, mode_next;
    logic [7:0]         pend_reg, pend_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [7:0]         wbuf_reg  [KEYWORD_MAX_LEN];
    logic [7:0]         wbuf_next [KEYWORD_MAX_LEN];
    logic [LEN_W-1:0]   wlen_reg, wlen_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [LINE_W-1:0]  cstart_reg, cstart_next;
    logic [LINE_W-1:0]  first_reg;

    logic [CHARS_W-1:0] chars_w;
    logic [KIND_W-1:0]  word_kind_w;
    logic               accept;
    logic               a_vld, b_vld;
    token_t             a_tok, b_tok;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        chars_w = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < NAME_OUT_CHARS && i < KEYWORD_MAX_LEN && LEN_W'(i) < wlen_reg)
                chars_w[8*i +: 8] = wbuf_reg[i];
        end
    end

    always_comb
    begin
        logic hit;
        word_kind_w = K_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--)
        begin
            hit = (wlen_reg == LEN_W'(KW_LEN[k]));
            for (int j = 0; j < KW_TEXT; j++)
            begin
                if (j < int'(KW_LEN[k]) && wbuf_reg[j] != KW_STR[k][8*j +: 8])
                    hit = 1'b0;
            end
            if (hit)
                word_kind_w = KW_KIND[k];
        end
    end

    always_comb
    begin
        logic [KIND_W:0]    pk;
        logic               rescan;
        logic [VALUE_W+3:0] prod;
        token_t             flush_tok;

        mode_next   = mode_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        wbuf_next   = wbuf_reg;
        wlen_next   = wlen_reg;
        line_next   = line_reg;
        cstart_next = cstart_reg;
        a_vld  = 1'b0;
        b_vld  = 1'b0;
        a_tok  = '0;
        b_tok  = '0;
        rescan = 1'b0;
        pk     = pair_kind(pend_reg, in_char);
        prod   = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                 + (VALUE_W+4)'(in_char - 8'h30);

        flush_tok      = '0;
        flush_tok.line = line_reg;
        case (mode_reg)
            MODE_COMMENT:
            begin
                flush_tok.kind  = K_BADCOMMENT;
                flush_tok.value = VALUE_W'(cstart_reg);
            end
            MODE_NUMBER:
            begin
                flush_tok.kind  = K_NUMBER;
                flush_tok.value = acc_reg;
                flush_tok.chars = chars_w;
                flush_tok.len   = wlen_reg;
            end
            MODE_WORD:
            begin
                flush_tok.kind  = word_kind_w;
                flush_tok.chars = chars_w;
                flush_tok.len   = wlen_reg;
            end
            MODE_OPER: flush_tok.kind = single_kind(pend_reg);
            default:   flush_tok.kind = K_UNKNOWN;
        endcase

        b_tok.line = line_reg;

        if (in_end)
        begin
            a_vld      = (mode_reg != MODE_IDLE);
            a_tok      = flush_tok;
            b_vld      = 1'b1;
            b_tok.kind = K_EOF;
            mode_next  = MODE_IDLE;
            pend_next  = '0;
            acc_next   = '0;
            wlen_next  = '0;
            line_next  = first_reg;
        end
        else
        begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (in_char == 8'h0a && line_reg != LINE_MAX)
                        line_next = line_reg + 1'b1;
                    if (in_char == 8'h7d)
                        mode_next = MODE_IDLE;
                end
                MODE_OPER:
                begin
                    a_vld     = 1'b1;
                    mode_next = MODE_IDLE;
                    if (!pk[KIND_W])
                    begin
                        a_tok      = '0;
                        a_tok.line = line_reg;
                        a_tok.kind = pk[KIND_W-1:0];
                    end
                    else
                    begin
                        a_tok  = flush_tok;
                        rescan = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(in_char))
                    begin
                        acc_next = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[VALUE_W-1:0];
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                            if (wlen_reg == LEN_W'(i)) wbuf_next[i] = in_char;
                        if (wlen_reg != {LEN_W{1'b1}}) wlen_next = wlen_reg + 1'b1;
                    end
                    else
                    begin
                        a_vld     = 1'b1;
                        a_tok     = flush_tok;
                        mode_next = MODE_IDLE;
                        rescan    = 1'b1;
                    end
                end
                MODE_WORD:
                begin
                    if (is_digit(in_char) || is_alpha(in_char))
                    begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++)
                            if (wlen_reg == LEN_W'(i)) wbuf_next[i] = in_char;
                        if (wlen_reg != {LEN_W{1'b1}}) wlen_next = wlen_reg + 1'b1;
                    end
                    else
                    begin
                        a_vld     = 1'b1;
                        a_tok     = flush_tok;
                        mode_next = MODE_IDLE;
                        rescan    = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    rescan    = 1'b1;
                end
            endcase

            if (rescan)
            begin
                b_vld = 1'b1;
                case (in_char)
                    8'h3d, 8'h21, 8'h3e, 8'h3c, 8'h7c, 8'h26:
                    begin
                        b_vld     = 1'b0;
                        pend_next = in_char;
                        mode_next = MODE_OPER;
                    end
                    8'h7b:
                    begin
                        b_vld       = 1'b0;
                        cstart_next = line_reg;
                        mode_next   = MODE_COMMENT;
                    end
                    8'h25:   b_tok.kind = K_MOD;
                    8'h28:   b_tok.kind = K_LPAREN;
                    8'h29:   b_tok.kind = K_RPAREN;
                    8'h2a:   b_tok.kind = K_MUL;
                    8'h2b:   b_tok.kind = K_ADD;
                    8'h2c:   b_tok.kind = K_COMMA;
                    8'h2d:   b_tok.kind = K_SUB;
                    8'h2e:   b_tok.kind = K_PERIOD;
                    8'h2f:   b_tok.kind = K_DIV;
                    8'h3b:   b_tok.kind = K_SEMI;
                    8'h5e:   b_tok.kind = K_XOR;
                    default:
                    begin
                        if (is_space(in_char))
                        begin
                            b_vld = 1'b0;
                            if (in_char == 8'h0a && line_reg != LINE_MAX)
                                line_next = line_reg + 1'b1;
                        end
                        else if (is_digit(in_char) || is_alpha(in_char))
                        begin
                            b_vld        = 1'b0;
                            wbuf_next[0] = in_char;
                            wlen_next    = LEN_W'(1);
                            if (is_digit(in_char))
                            begin
                                acc_next  = VALUE_W'(in_char - 8'h30);
                                mode_next = MODE_NUMBER;
                            end
                            else
                                mode_next = MODE_WORD;
                        end
                        else
                        begin
                            b_tok.kind  = K_UNKNOWN;
                            b_tok.value = VALUE_W'(in_char);
                        end
                    end
                endcase
            end
        end
    end

    assign push_valid     = accept && (a_vld || b_vld);
    assign push_pair.two  = a_vld && b_vld;
    assign push_pair.tok0 = a_vld ? a_tok : b_tok;
    assign push_pair.tok1 = b_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pend_reg   <= '0;
            acc_reg    <= '0;
            wlen_reg   <= '0;
            line_reg   <= LINE_W'(1);
            cstart_reg <= '0;
            first_reg  <= LINE_W'(1);
        end
        else
        begin
            if (cfg_we)
                first_reg <= cfg_wdata;
            if (accept)
            begin
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                acc_reg    <= acc_next;
                wlen_reg   <= wlen_next;
                line_reg   <= line_next;
                cstart_reg <= cstart_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            wbuf_reg <= wbuf_next;
    end

endmodule

// File: rtl/stok_back.sv
// Token queue and output sequencer: hands out one or two tokens per entry.
module stok_back
    import stok_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  tok_pair_t push_pair,
    output logic      push_ready,
    output logic      out_valid,
    output token_t    out_tok,
    output logic      out_last,
    input  logic      out_ready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    tok_pair_t       mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            sel_reg;
    tok_pair_t       head;
    logic            do_push, do_pop;

    assign head       = mem_reg[rd_reg];
    assign push_ready = (cnt_reg != CW'(QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign out_valid  = (cnt_reg != '0);
    assign out_tok    = sel_reg ? head.tok1 : head.tok0;
    assign out_last   = sel_reg || !head.two;
    assign do_pop     = out_valid && out_ready && out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!do_push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
            // Advance to the second token of an entry, back to the first on pop.
            if (out_valid && out_ready)
                sel_reg <= !out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_pair;
    end

endmodule

// File: tb/source_tokenizer_tb.sv
// Randomized self-checking testbench for the source tokenizer.
module source_tokenizer_tb;
    import stok_pkg::*;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [LINE_W-1:0]  line;
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   len;
        logic               last;
    } tok_rec_t;

    // Scoreboard: predicts tokens from accepted requests, checks emitted tokens.
    class token_scoreboard;
        tok_rec_t    pending_tokens[$];
        int          mismatches;
        logic [23:0] first_line;
        scan_mode_t  mode;
        logic [7:0]  op_char;
        logic [30:0] num_acc;
        logic [7:0]  word_buf[9];
        logic [7:0]  word_len;
        logic [23:0] line_cnt;
        logic [23:0] comment_line;
        tok_rec_t    new_toks[$];

        function void init();
            first_line = 1;
            mode = MODE_IDLE;
            op_char = 0;
            num_acc = 0;
            word_len = 0;
            line_cnt = 1;
            comment_line = 0;
            mismatches = 0;
            foreach (word_buf[i]) word_buf[i] = 0;
        endfunction

        function void set_first_line(logic [23:0] v);
            first_line = v;
        endfunction

        function void push_tok(logic [5:0] k, logic [30:0] v, bit with_name);
            tok_rec_t t;
            t.kind = k;
            t.value = v;
            t.line = line_cnt;
            t.chars = 0;
            t.len = 0;
            t.last = 0;
            if (with_name)
            begin
                for (int i = 0; i < 8 && i < word_len; i++)
                    t.chars[8*i +: 8] = word_buf[i];
                t.len = word_len;
            end
            new_toks = {new_toks, t};
        endfunction

        function void bump_line();
            if (line_cnt != LINE_MAX) line_cnt++;
        endfunction

        function void add_char(logic [7:0] c);
            if (word_len < 9) word_buf[word_len] = c;
            if (word_len != 8'd255) word_len++;
        endfunction

        function logic [5:0] word_kind();
            logic hit;
            if (word_len <= 9)
                for (int k = 0; k < KW_NUM; k++)
                begin
                    if (KW_LEN[k] != word_len) continue;
                    hit = 1;
                    for (int i = 0; i < word_len; i++)
                        if (KW_STR[k][8*i +: 8] != word_buf[i]) hit = 0;
                    if (hit) return KW_KIND[k];
                end
            return K_IDENT;
        endfunction

        function logic [5:0] one_char_op(logic [7:0] c);
            case (c)
                "=":     return K_ASSIGN;
                "!":     return K_NOT;
                ">":     return K_GT;
                "<":     return K_LT;
                "|":     return K_BOR;
                default: return K_BAND;
            endcase
        endfunction

        function void flush_token();
            case (mode)
                MODE_COMMENT: push_tok(K_BADCOMMENT, 31'(comment_line), 0);
                MODE_NUMBER:  push_tok(K_NUMBER, num_acc, 1);
                MODE_WORD:    push_tok(word_kind(), 0, 1);
                MODE_OPER:    push_tok(one_char_op(op_char), 0, 0);
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        function void scan_byte(logic [7:0] c);
            case (c)
                "=", "!", ">", "<", "|", "&":
                begin
                    op_char = c;
                    mode = MODE_OPER;
                end
                "{":
                begin
                    comment_line = line_cnt;
                    mode = MODE_COMMENT;
                end
                "%": push_tok(K_MOD, 0, 0);
                "(": push_tok(K_LPAREN, 0, 0);
                ")": push_tok(K_RPAREN, 0, 0);
                "*": push_tok(K_MUL, 0, 0);
                "+": push_tok(K_ADD, 0, 0);
                ",": push_tok(K_COMMA, 0, 0);
                "-": push_tok(K_SUB, 0, 0);
                ".": push_tok(K_PERIOD, 0, 0);
                "/": push_tok(K_DIV, 0, 0);
                ";": push_tok(K_SEMI, 0, 0);
                "^": push_tok(K_XOR, 0, 0);
                default:
                begin
                    if (c == " " || (c >= 9 && c <= 13))
                    begin
                        if (c == 8'h0a) bump_line();
                    end
                    else if (c >= "0" && c <= "9")
                    begin
                        word_len = 0;
                        add_char(c);
                        num_acc = 31'(c - "0");
                        mode = MODE_NUMBER;
                    end
                    else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                    begin
                        word_len = 0;
                        add_char(c);
                        mode = MODE_WORD;
                    end
                    else
                        push_tok(K_UNKNOWN, 31'(c), 0);
                end
            endcase
        endfunction

        // Note one accepted request and queue the tokens it causes.
        function void note_request(logic [7:0] c, logic fin);
            logic [6:0]  pk;
            logic [34:0] v;
            logic        alnum;
            bit          again;
            new_toks.delete();
            alnum = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                    (c >= "A" && c <= "Z");
            if (fin)
            begin
                flush_token();
                push_tok(K_EOF, 0, 0);
                op_char = 0;
                num_acc = 0;
                word_len = 0;
                line_cnt = first_line;
            end
            else
            begin
                again = 1;
                case (mode)
                    MODE_COMMENT:
                    begin
                        if (c == 8'h0a) bump_line();
                        if (c == "}") mode = MODE_IDLE;
                        again = 0;
                    end
                    MODE_OPER:
                    begin
                        pk = {1'b1, K_UNKNOWN};
                        case (op_char)
                            "=": if (c == "=") pk = {1'b0, K_EQ};
                            "!": if (c == "=") pk = {1'b0, K_NE};
                            ">": if (c == ">") pk = {1'b0, K_RSHIFT};
                                 else if (c == "=") pk = {1'b0, K_GE};
                            "<": if (c == "<") pk = {1'b0, K_LSHIFT};
                                 else if (c == "=") pk = {1'b0, K_LE};
                            "|": if (c == "|") pk = {1'b0, K_LOR};
                            "&": if (c == "&") pk = {1'b0, K_LAND};
                            default: ;
                        endcase
                        if (!pk[6])
                        begin
                            push_tok(pk[5:0], 0, 0);
                            mode = MODE_IDLE;
                            again = 0;
                        end
                        else
                            flush_token();
                    end
                    MODE_NUMBER:
                    begin
                        if (c >= "0" && c <= "9")
                        begin
                            v = 35'(num_acc) * 10 + 35'(c - "0");
                            num_acc = (v > 35'(NUM_MAX)) ? NUM_MAX : v[30:0];
                            add_char(c);
                            again = 0;
                        end
                        else
                            flush_token();
                    end
                    MODE_WORD:
                    begin
                        if (alnum)
                        begin
                            add_char(c);
                            again = 0;
                        end
                        else
                            flush_token();
                    end
                    default: mode = MODE_IDLE;
                endcase
                if (again) scan_byte(c);
            end
            if (new_toks.size() > 0) new_toks[$].last = 1;
            pending_tokens = {pending_tokens, new_toks};
        endfunction

        // Check one emitted token against the oldest prediction.
        function void check_token(tok_rec_t got);
            tok_rec_t want;
            if (pending_tokens.size() == 0)
            begin
                report("token with nothing expected", got, got);
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind)   report("token_kind", got, want);
            if (got.value !== want.value) report("token_value", got, want);
            if (got.line !== want.line)   report("line_number", got, want);
            if (got.chars !== want.chars) report("name_chars", got, want);
            if (got.len !== want.len)     report("name_length", got, want);
            if (got.last !== want.last)   report("last_of_item", got, want);
        endfunction

        function void report(string what, tok_rec_t got, tok_rec_t want);
            mismatches++;
            if (mismatches <= 50)
                $display("MISMATCH %s: got kind %0d val %0d line %0d chars %h len %0d last %0d,"
                         , what, got.kind, got.value, got.line, got.chars, got.len, got.last,
                         " want kind %0d val %0d line %0d chars %h len %0d last %0d",
                         want.kind, want.value, want.line, want.chars, want.len, want.last);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [23:0] cfg_wdata;

    stok_src_if src ();
    stok_tok_if tok ();

    source_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .src      (src),
        .tok      (tok)
    );

    token_scoreboard sb;
    int  send_idle_pct;
    int  stall_pct;
    bit  hold_off;
    int  idle_cycles;
    bit  timed_out;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watch both channels: note requests, check tokens, count quiet cycles.
    always @(posedge clk)
    begin
        tok_rec_t t;
        if (rst_n)
        begin
            if (src.valid && src.ready) sb.note_request(src.char_in, src.at_end);
            if (tok.valid && tok.ready)
            begin
                t.kind = tok.token_kind;
                t.value = tok.token_value;
                t.line = tok.line_number;
                t.chars = tok.name_chars;
                t.len = tok.name_length;
                t.last = tok.last_of_item;
                sb.check_token(t);
            end
            if ((src.valid && src.ready) || (tok.valid && tok.ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall at random per phase, or hold off entirely under pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok.ready <= 0;
        else
            tok.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // Drive one request and wait for it to be taken; idle at random first.
    task automatic send_request(logic [7:0] c, logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            src.valid <= 0;
            @(posedge clk);
        end
        src.valid <= 1;
        src.char_in <= c;
        src.at_end <= fin;
        do @(posedge clk); while (!src.ready);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_request(s[i], 0);
    endtask

    // Drop valid and wait until every predicted token has come out.
    task automatic drain();
        src.valid <= 0;
        @(posedge clk);
        while (sb.pending_tokens.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_first_line(logic [23:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_first_line(v);
    endtask

    // Random byte biased toward lexically interesting characters.
    function automatic logic [7:0] pick_byte();
        string alpha = "=!<>|&{}%()*+,-./;^ \n\t0123456789abcdefghijklmnopqrstuvwxyz";
        int r;
        r = $urandom_range(99);
        if (r < 8) return 8'($urandom_range(255));
        if (r < 20) return alpha[$urandom_range(alpha.len() - 1)];
        if (r < 30) return 8'("0" + $urandom_range(9));
        if (r < 35) return 8'("A" + $urandom_range(25));
        return alpha[$urandom_range(19)];
    endfunction

    // Emit a random sentence: keywords, words, numbers, operators, comments, newlines, random bytes.
    task automatic send_phrase();
        string kws[15] = '{"const", "var", "procedure", "function", "call", "begin",
                           "end", "if", "then", "else", "while", "do", "repeat",
                           "until", "mod"};
        string ops[14] = '{"==", "!=", "<=", ">=", "<<", ">>", "||", "&&", "=", "<",
                           ">", "|", "&", "!"};
        int n;
        n = $urandom_range(8, 2);
        repeat (n)
        begin
            case ($urandom_range(6))
                0: send_text(kws[$urandom_range(14)]);
                1: repeat ($urandom_range(12, 1))
                       send_request(8'("a" + $urandom_range(25)), 0);
                2: repeat ($urandom_range(12, 1))
                       send_request(8'("0" + $urandom_range(9)), 0);
                3: send_text(ops[$urandom_range(13)]);
                4: send_text("{ x\ny }");
                5: send_request(pick_byte(), 0);
                default: send_request("\n", 0);
            endcase
            if ($urandom_range(1)) send_request(" ", 0);
        end
    endtask

    task automatic run_random(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 7) send_phrase();
            else repeat ($urandom_range(10, 1)) send_request(pick_byte(), 0);
            sent += 20;
            if ($urandom_range(9) == 0) send_request(pick_byte(), 1);
        end
        send_request(0, 1);
    endtask

    // Watchdog: end the run if nothing moves for too long.
    initial
    begin
        timed_out = 0;
        wait (rst_n);
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired with %0d tokens outstanding", sb.pending_tokens.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int pressure_cycles;
        sb = new();
        sb.init();
        idle_cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        src.valid = 0;
        src.char_in = 0;
        src.at_end = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: every operator, keywords, long names, saturation, special cases.
        send_text("== != <= >= << >> || && = ! < > | & |x");
        send_text("%()*+,-./;^ procedure function callx Abcdefghijk ");
        send_text("99999999999 0 {c\n} ");
        send_request(8'hff, 0);
        send_request(8'h80, 0);
        send_request(8'h01, 0);
        send_text("{open\n");
        send_request(0, 1);
        send_text("<");
        send_request(0, 1);
        send_request(0, 1);
        drain();

        // Line count near the top, saturating at its maximum; then a first line of zero.
        write_first_line(24'hfffffe);
        send_request(0, 1);
        send_text("\n\n\nx\n{\n}7");
        send_request(0, 1);
        drain();
        write_first_line(24'd0);
        send_request(0, 1);
        send_text("a\nb");
        send_request(0, 1);
        drain();
        write_first_line(24'd1);
        send_request(0, 1);

        // Idling phases: none, sender, receiver, both.
        send_idle_pct = 0;  stall_pct = 0;  run_random(500);
        send_idle_pct = 60; stall_pct = 0;  run_random(400);
        drain();
        write_first_line(24'($urandom));
        send_request(0, 1);
        send_idle_pct = 0;  stall_pct = 60; run_random(400);
        send_idle_pct = 9;  stall_pct = 9;  run_random(400);

        // Pressure: hold the receiver off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                pressure_cycles = 0;
                while (pressure_cycles < 200)
                begin
                    @(posedge clk);
                    pressure_cycles++;
                end
                hold_off = 0;
            end
            begin
                send_idle_pct = 0;
                run_random(300);
            end
        join
        drain();

        repeat (50) @(posedge clk);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: source_tokenizer.f
rtl/stok_pkg.sv
rtl/stok_ifs.sv
rtl/stok_front.sv
rtl/stok_back.sv
rtl/source_tokenizer.sv
tb/source_tokenizer_tb.sv
